// ===== rtl/lsnf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, byte class codes and defaults for the longest signed number finder.
// Depends on nothing; every other file in rtl imports it.
package lsnf_pkg;

  // Default capacity of one line in bytes.
  localparam int MAX_CHARS_DEF = 65536;

  // Fixed widths of the result fields.
  localparam int START_OUT_W = 16;
  localparam int LEN_OUT_W   = 17;

  // Byte classes.
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OTHER = 2'd0;
  localparam cls_t CLS_DIGIT = 2'd1;
  localparam cls_t CLS_SIGN  = 2'd2;
  localparam cls_t CLS_DOT   = 2'd3;

  // One request: a byte of the line and the end-of-line mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  // One result per line.
  typedef struct packed {
    logic [START_OUT_W-1:0] best_start;
    logic [LEN_OUT_W-1:0]   best_length;
    logic                   overflow;
  } out_t;

  // Sort a raw byte into one of the four classes.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = CLS_DIGIT;
    end else if (c == 8'h2B || c == 8'h2D) begin
      r = CLS_SIGN;
    end else if (c == 8'h2E) begin
      r = CLS_DOT;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lsnf_scan.sv =====
`timescale 1ns / 1ps
// Input register and per-byte token tracker of the longest signed number finder.
// Depends on lsnf_pkg. Hands the line state to lsnf_close on the last byte.
module lsnf_scan import lsnf_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  localparam int POS_W   = $clog2(MAX_CHARS + 1),
  localparam int START_W = $clog2(MAX_CHARS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               cl_valid,
  input  logic               cl_stall,
  output cls_t               cl_prev_class,
  output logic [START_W-1:0] cl_run_start,
  output logic [POS_W-1:0]   cl_run_length,
  output logic               cl_run_signed,
  output logic [START_W-1:0] cl_held_start,
  output logic [POS_W-1:0]   cl_held_length,
  output logic               cl_held_valid,
  output logic               cl_dot_pending,
  output logic [START_W-1:0] cl_best_start,
  output logic [POS_W-1:0]   cl_best_length,
  output logic               cl_overflow
);

  // Input register.
  logic s1_valid;
  in_t  s1_data;
  logic s1_adv;

  // Line state.
  logic [POS_W-1:0]   position;
  cls_t               prev_class;
  logic [START_W-1:0] run_start;
  logic [POS_W-1:0]   run_length;
  logic               run_signed;
  logic [START_W-1:0] held_start;
  logic [POS_W-1:0]   held_length;
  logic               held_valid;
  logic               dot_pending;
  logic [START_W-1:0] best_start;
  logic [POS_W-1:0]   best_length;
  logic               overflow_flag;

  logic [POS_W-1:0]   position_next;
  cls_t               prev_class_next;
  logic [START_W-1:0] run_start_next;
  logic [POS_W-1:0]   run_length_next;
  logic               run_signed_next;
  logic [START_W-1:0] held_start_next;
  logic [POS_W-1:0]   held_length_next;
  logic               held_valid_next;
  logic               dot_pending_next;
  logic [START_W-1:0] best_start_next;
  logic [POS_W-1:0]   best_length_next;
  logic               overflow_next;

  // Candidate offered by this byte.
  cls_t               cls;
  logic               cand_en;
  logic [START_W-1:0] cand_start;
  logic [POS_W-1:0]   cand_len;

  // A last byte waits while the close stage is stalled; other bytes always move.
  assign s1_adv   = s1_valid && !(s1_data.last && cl_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign cl_valid = s1_valid && s1_data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Token tracking for one byte; at most one candidate is offered per byte.
  always_comb begin
    cls              = classify(s1_data.ch);
    position_next    = position;
    prev_class_next  = prev_class;
    run_start_next   = run_start;
    run_length_next  = run_length;
    run_signed_next  = run_signed;
    held_start_next  = held_start;
    held_length_next = held_length;
    held_valid_next  = held_valid;
    dot_pending_next = dot_pending;
    overflow_next    = overflow_flag;
    cand_en          = 1'b0;
    cand_start       = run_start;
    cand_len         = POS_W'(run_signed) + run_length;

    if (position >= POS_W'(MAX_CHARS)) begin
      overflow_next = 1'b1;
    end else begin
      position_next   = position + POS_W'(1);
      prev_class_next = cls;
      if (cls == CLS_DIGIT) begin
        if (prev_class != CLS_DIGIT) begin
          run_signed_next  = (prev_class == CLS_SIGN);
          run_start_next   = START_W'(position) - START_W'(prev_class == CLS_SIGN);
          run_length_next  = POS_W'(1);
          dot_pending_next = 1'b0;
        end else begin
          run_length_next = run_length + POS_W'(1);
        end
      end else if (dot_pending) begin
        cand_en          = 1'b1;
        cand_start       = held_start;
        cand_len         = held_length;
        held_valid_next  = 1'b0;
        dot_pending_next = 1'b0;
      end else if (prev_class == CLS_DIGIT) begin
        // A held integer part with its fraction beats the bare fraction run.
        if (held_valid) begin
          cand_en         = 1'b1;
          cand_start      = held_start;
          cand_len        = held_length + POS_W'(1) + run_length;
          held_valid_next = 1'b0;
        end else if (cls != CLS_DOT) begin
          cand_en = 1'b1;
        end
        if (cls == CLS_DOT) begin
          held_start_next  = run_start;
          held_length_next = POS_W'(run_signed) + run_length;
          held_valid_next  = 1'b1;
          dot_pending_next = 1'b1;
        end
      end
    end

    // Later candidates win ties.
    best_start_next  = best_start;
    best_length_next = best_length;
    if (cand_en && cand_len != '0 && cand_len >= best_length) begin
      best_start_next  = cand_start;
      best_length_next = cand_len;
    end
  end

  // State after this byte goes to the close stage at end of line.
  assign cl_prev_class  = prev_class_next;
  assign cl_run_start   = run_start_next;
  assign cl_run_length  = run_length_next;
  assign cl_run_signed  = run_signed_next;
  assign cl_held_start  = held_start_next;
  assign cl_held_length = held_length_next;
  assign cl_held_valid  = held_valid_next;
  assign cl_dot_pending = dot_pending_next;
  assign cl_best_start  = best_start_next;
  assign cl_best_length = best_length_next;
  assign cl_overflow    = overflow_next;

  // State registers; the last byte of a line clears them for the next line.
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_data.last)) begin
      position      <= '0;
      prev_class    <= CLS_OTHER;
      run_start     <= '0;
      run_length    <= '0;
      run_signed    <= 1'b0;
      held_start    <= '0;
      held_length   <= '0;
      held_valid    <= 1'b0;
      dot_pending   <= 1'b0;
      best_start    <= '0;
      best_length   <= '0;
      overflow_flag <= 1'b0;
    end else if (s1_adv) begin
      position      <= position_next;
      prev_class    <= prev_class_next;
      run_start     <= run_start_next;
      run_length    <= run_length_next;
      run_signed    <= run_signed_next;
      held_start    <= held_start_next;
      held_length   <= held_length_next;
      held_valid    <= held_valid_next;
      dot_pending   <= dot_pending_next;
      best_start    <= best_start_next;
      best_length   <= best_length_next;
      overflow_flag <= overflow_next;
    end
  end

endmodule

// ===== rtl/lsnf_close.sv =====
`timescale 1ns / 1ps
// End-of-line stage and result register of the longest signed number finder.
// Depends on lsnf_pkg. Closes the open token and forms the result.
module lsnf_close import lsnf_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  localparam int POS_W   = $clog2(MAX_CHARS + 1),
  localparam int START_W = $clog2(MAX_CHARS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cl_valid,
  output logic               cl_stall,
  input  cls_t               cl_prev_class,
  input  logic [START_W-1:0] cl_run_start,
  input  logic [POS_W-1:0]   cl_run_length,
  input  logic               cl_run_signed,
  input  logic [START_W-1:0] cl_held_start,
  input  logic [POS_W-1:0]   cl_held_length,
  input  logic               cl_held_valid,
  input  logic               cl_dot_pending,
  input  logic [START_W-1:0] cl_best_start,
  input  logic [POS_W-1:0]   cl_best_length,
  input  logic               cl_overflow,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  // Close stage registers.
  logic               cb_valid;
  logic               cb_adv;
  cls_t               prev_class;
  logic [START_W-1:0] run_start;
  logic [POS_W-1:0]   run_length;
  logic               run_signed;
  logic [START_W-1:0] held_start;
  logic [POS_W-1:0]   held_length;
  logic               held_valid;
  logic               dot_pending;
  logic [START_W-1:0] best_start;
  logic [POS_W-1:0]   best_length;
  logic               overflow_flag;

  logic               cand_en;
  logic [START_W-1:0] cand_start;
  logic [POS_W-1:0]   cand_len;
  logic [START_W-1:0] fin_start;
  logic [POS_W-1:0]   fin_len;

  assign cb_adv   = cb_valid && !(out_valid && out_stall);
  assign cl_stall = cb_valid && !cb_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cb_valid <= 1'b0;
    end else if (!cl_stall) begin
      cb_valid <= cl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cl_valid && !cl_stall) begin
      prev_class    <= cl_prev_class;
      run_start     <= cl_run_start;
      run_length    <= cl_run_length;
      run_signed    <= cl_run_signed;
      held_start    <= cl_held_start;
      held_length   <= cl_held_length;
      held_valid    <= cl_held_valid;
      dot_pending   <= cl_dot_pending;
      best_start    <= cl_best_start;
      best_length   <= cl_best_length;
      overflow_flag <= cl_overflow;
    end
  end

  // End of line acts as a byte of the other class: offer what is still open.
  always_comb begin
    cand_en    = 1'b0;
    cand_start = run_start;
    cand_len   = POS_W'(run_signed) + run_length;
    if (dot_pending) begin
      cand_en    = 1'b1;
      cand_start = held_start;
      cand_len   = held_length;
    end else if (prev_class == CLS_DIGIT) begin
      cand_en = 1'b1;
      if (held_valid) begin
        cand_start = held_start;
        cand_len   = held_length + POS_W'(1) + run_length;
      end
    end
    fin_start = best_start;
    fin_len   = best_length;
    if (cand_en && cand_len != '0 && cand_len >= best_length) begin
      fin_start = cand_start;
      fin_len   = cand_len;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= cb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cb_adv) begin
      out_data.best_start  <= (fin_len != '0) ? START_OUT_W'(fin_start) : '0;
      out_data.best_length <= LEN_OUT_W'(fin_len);
      out_data.overflow    <= overflow_flag;
    end
  end

endmodule

// ===== rtl/longest_signed_number_finder.sv =====
`timescale 1ns / 1ps
// Top level of the longest signed number finder: byte scanner and end-of-line stage.
// Depends on lsnf_pkg, lsnf_scan and lsnf_close.
//
//   Channel  Direction  Handshake            Payload
//   in       request    in_valid / in_stall  in_data   (ch, last)
//   out      result     out_valid/out_stall  out_data  (best_start, best_length, overflow)
//
// One byte is taken every cycle unless in_stall is high; each byte updates the
// line state in the scan stage, right after the input register.
// After the last byte of a line is accepted, the result passes the input
// register, the close stage and then the result register.
// in_stall rises only when a last byte waits behind a full close stage and a
// stalled result. Reset is synchronous and leaves the block empty and idle.
module longest_signed_number_finder import lsnf_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int POS_W   = $clog2(MAX_CHARS + 1);
  localparam int START_W = $clog2(MAX_CHARS);

  logic               cl_valid;
  logic               cl_stall;
  cls_t               cl_prev_class;
  logic [START_W-1:0] cl_run_start;
  logic [POS_W-1:0]   cl_run_length;
  logic               cl_run_signed;
  logic [START_W-1:0] cl_held_start;
  logic [POS_W-1:0]   cl_held_length;
  logic               cl_held_valid;
  logic               cl_dot_pending;
  logic [START_W-1:0] cl_best_start;
  logic [POS_W-1:0]   cl_best_length;
  logic               cl_overflow;

  // Per-byte scanner.
  lsnf_scan #(
    .MAX_CHARS(MAX_CHARS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .cl_valid      (cl_valid),
    .cl_stall      (cl_stall),
    .cl_prev_class (cl_prev_class),
    .cl_run_start  (cl_run_start),
    .cl_run_length (cl_run_length),
    .cl_run_signed (cl_run_signed),
    .cl_held_start (cl_held_start),
    .cl_held_length(cl_held_length),
    .cl_held_valid (cl_held_valid),
    .cl_dot_pending(cl_dot_pending),
    .cl_best_start (cl_best_start),
    .cl_best_length(cl_best_length),
    .cl_overflow   (cl_overflow)
  );

  // End-of-line stage and result register.
  lsnf_close #(
    .MAX_CHARS(MAX_CHARS)
  ) u_close (
    .clk           (clk),
    .rst           (rst),
    .cl_valid      (cl_valid),
    .cl_stall      (cl_stall),
    .cl_prev_class (cl_prev_class),
    .cl_run_start  (cl_run_start),
    .cl_run_length (cl_run_length),
    .cl_run_signed (cl_run_signed),
    .cl_held_start (cl_held_start),
    .cl_held_length(cl_held_length),
    .cl_held_valid (cl_held_valid),
    .cl_dot_pending(cl_dot_pending),
    .cl_best_start (cl_best_start),
    .cl_best_length(cl_best_length),
    .cl_overflow   (cl_overflow),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

// ===== rtl/lsnf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the longest signed number finder, bound to its top level.
// Depends on lsnf_pkg.
module lsnf_checker import lsnf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A stalled request is held until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // A line without a token reports start zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.best_length == '0 |-> out_data.best_start == '0)
    else $error("empty result has nonzero start");

  // With the result register empty the pipeline can always take a request.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("request stalled while no result is held");

  // Reset leaves no result behind.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind longest_signed_number_finder lsnf_checker u_lsnf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for longest_signed_number_finder: lines of bytes go in,
// one result per line is predicted and compared field by field as it comes out.
// Depends on lsnf_pkg and the RTL of longest_signed_number_finder.
module testbench;
  import lsnf_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int IDLE_LIMIT = 4000;
  // Length of the long output hold-off in the back-pressure test.
  localparam int LONG_HOLD = 300;
  // Bytes of random lines to send.
  localparam int RANDOM_BYTES = 900;

  // Output stall patterns.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Line state of the predictor.
  logic [16:0] line_pos;
  cls_t        prev_cls;
  logic [15:0] digits_start;
  logic [16:0] digits_len;
  logic        digits_signed;
  logic [15:0] int_part_start;
  logic [16:0] int_part_len;
  logic        int_part_valid;
  logic        dot_seen;
  logic [15:0] longest_start;
  logic [16:0] longest_len;
  logic        past_capacity;

  out_t expected_results[$];

  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int long_holds = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b0;
  int hold_ask = 0;

  longest_signed_number_finder u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sort a byte into digit, sign, dot or other.
  function automatic cls_t byte_class(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return CLS_DIGIT;
    end
    if (c == 8'h2B || c == 8'h2D) begin
      return CLS_SIGN;
    end
    if (c == 8'h2E) begin
      return CLS_DOT;
    end
    return CLS_OTHER;
  endfunction

  // A finished token replaces the longest one so far when it is at least as long.
  task automatic note_token(input logic [15:0] start, input logic [16:0] len);
    if (len != 0 && len >= longest_len) begin
      longest_start = start;
      longest_len   = len;
    end
  endtask

  task automatic clear_line_state();
    line_pos       = '0;
    prev_cls       = CLS_OTHER;
    digits_start   = '0;
    digits_len     = '0;
    digits_signed  = 1'b0;
    int_part_start = '0;
    int_part_len   = '0;
    int_part_valid = 1'b0;
    dot_seen       = 1'b0;
    longest_start  = '0;
    longest_len    = '0;
    past_capacity  = 1'b0;
  endtask

  // Advance the token tracking by one byte class at the given position.
  task automatic track_class(input cls_t c, input logic [16:0] at);
    logic [16:0] whole;
    if (c == CLS_DIGIT) begin
      if (prev_cls != CLS_DIGIT) begin
        digits_signed = (prev_cls == CLS_SIGN);
        digits_start  = 16'(at - 17'(digits_signed));
        digits_len    = 17'd1;
        // A digit run after a dot becomes the fraction of the held integer part.
        dot_seen      = 1'b0;
      end else begin
        digits_len = digits_len + 17'd1;
      end
    end else if (dot_seen) begin
      // The dot was not followed by a digit, so only the integer part counts.
      note_token(int_part_start, int_part_len);
      int_part_valid = 1'b0;
      dot_seen       = 1'b0;
    end else if (prev_cls == CLS_DIGIT) begin
      whole = digits_len + 17'(digits_signed);
      if (int_part_valid) begin
        note_token(int_part_start, int_part_len + 17'd1 + digits_len);
        int_part_valid = 1'b0;
      end
      if (c == CLS_DOT) begin
        int_part_start = digits_start;
        int_part_len   = whole;
        int_part_valid = 1'b1;
        dot_seen       = 1'b1;
      end else begin
        note_token(digits_start, whole);
      end
    end
    prev_cls = c;
  endtask

  // Work out the effect of one accepted request; a last byte queues the line result.
  task automatic predict_byte(input logic [7:0] c, input logic l);
    out_t res;
    if (int'(line_pos) >= MAX_CHARS_DEF) begin
      past_capacity = 1'b1;
    end else begin
      track_class(byte_class(c), line_pos);
      line_pos = line_pos + 17'd1;
    end
    if (l) begin
      track_class(CLS_OTHER, line_pos);
      res.best_start  = (longest_len != 0) ? longest_start : '0;
      res.best_length = longest_len;
      res.overflow    = past_capacity;
      expected_results.push_back(res);
      clear_line_state();
    end
  endtask

  // Offer one request until it is taken; the sender pauses between random bursts.
  task automatic send_byte(input logic [7:0] c, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{ch: c, last: l};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_byte(c, l);
    bytes_sent++;
    if (l) begin
      lines_sent++;
    end
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Withdraw the request so that nothing is taken twice while the sender is quiet.
  task automatic sender_pause();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Build one line from number-like pieces, or from raw noise now and then.
  task automatic send_random_line(output int nbytes);
    logic [7:0] text[$];
    int pieces;
    int ndig;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
        case ($urandom_range(0, 7))
          0: begin
            text.push_back(8'($urandom_range(0, 255)));
          end
          1: begin
            text.push_back(8'h20);
          end
          2: begin
            text.push_back(8'h2E);
          end
          default: begin
            if ($urandom_range(0, 1) == 1) begin
              text.push_back(($urandom_range(0, 1) == 1) ? 8'h2B : 8'h2D);
            end
            ndig = $urandom_range(1, 5);
            repeat (ndig) text.push_back(8'h30 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) begin
              text.push_back(8'h2E);
              if ($urandom_range(0, 3) != 0) begin
                ndig = $urandom_range(1, 4);
                repeat (ndig) text.push_back(8'h30 + 8'($urandom_range(0, 9)));
              end
            end
          end
        endcase
      end
    end
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
    nbytes = text.size();
  endtask

  // Short lines for signs, fractions, lone dots, ties, chained dots and odd bytes.
  task automatic test_directed_lines();
    sender_gaps = 1'b1;
    send_text("-7.25");
    send_text("1.x");
    send_text("+.5");
    send_text("12 34");
    send_text("1.2.3");
    send_text("9");
    send_byte(8'h00, 1'b0);
    send_byte(8'h2D, 1'b1);
    send_byte(8'hFF, 1'b1);
    sender_pause();
  endtask

  // Random lines, mostly well formed, some sent without any gaps.
  task automatic test_random_lines();
    int total;
    int n;
    total = 0;
    while (total < RANDOM_BYTES) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_random_line(n);
      total += n;
    end
    sender_pause();
  endtask

  // Hold the output for a long stretch while short lines keep coming.
  task automatic test_output_backpressure();
    int n;
    sender_gaps = 1'b0;
    hold_ask <= hold_ask + 1;
    repeat (40) begin
      if ($urandom_range(0, 1) == 1) begin
        send_text("-3.4");
      end else begin
        send_random_line(n);
      end
    end
    sender_pause();
  endtask

  // One long line whose signed number with a fraction starts far from the line start.
  task automatic test_long_line();
    sender_gaps = 1'b0;
    repeat (120) send_byte(8'h61, 1'b0);
    send_byte(8'h2D, 1'b0);
    repeat (60) send_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    send_byte(8'h2E, 1'b0);
    repeat (20) send_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    send_byte(8'h7A, 1'b1);
    sender_pause();
  endtask

  // Output stall: random patterns that change now and then, plus the requested long hold.
  initial begin
    stall_mode_t mode;
    int mode_left;
    int period;
    int phase;
    int hold_seen;
    mode      = STALL_NONE;
    mode_left = 0;
    period    = 2;
    phase     = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        long_holds++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
          period    = $urandom_range(2, 5);
        end
        mode_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= (phase % period == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result with none expected: start %0d, length %0d, overflow %0d",
               out_data.best_start, out_data.best_length, out_data.overflow);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.best_start !== want.best_start) begin
          $error("best_start: expected %0d, got %0d", want.best_start, out_data.best_start);
          mismatches++;
        end
        if (out_data.best_length !== want.best_length) begin
          $error("best_length: expected %0d, got %0d", want.best_length,
                 out_data.best_length);
          mismatches++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
          mismatches++;
        end
      end
    end
  end

  // Give up when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_line_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_random_lines();
    test_output_backpressure();
    test_long_line();
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    $display("Sent %0d lines in %0d bytes and checked %0d results,", lines_sent, bytes_sent,
             results_checked);
    $display("with %0d long output hold-offs and one line of over two hundred bytes.",
             long_holds);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lsnf_pkg.sv
rtl/lsnf_scan.sv
rtl/lsnf_close.sv
rtl/longest_signed_number_finder.sv
rtl/lsnf_checker.sv
sim/testbench.sv
